[sv/spm_pkg.sv]
// spm_pkg: shared types, constants and the dB-to-linear table function
// for the stereo peak meter ballistics unit. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package spm_pkg;

   localparam int DB_W       = 11;
   localparam int LEVEL_W    = 16;
   localparam int TIME_W     = 32;
   localparam int COEF_W     = 16;
   localparam int LUT_DEPTH  = 1 << DB_W;
   localparam int LUT_BIAS   = 1 << (DB_W - 1);
   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 64;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // register indexes on the csr channel
   localparam logic [CSR_IDX_W-1:0] CSR_DECAY_COEF      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PEAK_DECAY_COEF = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD_MS         = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FLOOR_DB        = 2'd3;

   localparam logic [COEF_W-1:0]  DECAY_COEF_RST      = 16'd60293;
   localparam logic [COEF_W-1:0]  PEAK_DECAY_COEF_RST = 16'd62259;
   localparam logic [COEF_W-1:0]  HOLD_MS_RST         = 16'd2000;
   localparam logic [DB_W-1:0]    FLOOR_DB_RST        = 11'h620; // -480

   typedef struct packed {
      logic [COEF_W-1:0] decay_coef;
      logic [COEF_W-1:0] peak_decay_coef;
      logic [COEF_W-1:0] hold_ms;
   } spm_cfg_type;

   typedef struct packed {
      logic               update;
      logic [LEVEL_W-1:0] target;
      logic [TIME_W-1:0]  now;
   } spm_chan_req_type;

   // table entry for index idx, which is the level in eighth dB offset by LUT_BIAS:
   // round(16384 * 10^(d/160)), saturated at full scale
   function automatic logic [LEVEL_W-1:0] lin_entry(input logic [DB_W-1:0] idx);
      real v;
      int  d;
      d = int'(idx) - LUT_BIAS;
      v = 16384.0 * $pow(10.0, real'(d) / 160.0) + 0.5;
      if (v >= 65535.0) begin
         return {LEVEL_W{1'b1}};
      end
      return LEVEL_W'($rtoi(v));
   endfunction

endpackage

`default_nettype wire

[sv/spm_lut.sv]
// spm_lut: dB-to-linear ROM with two registered read ports, one per channel.
// Depends on spm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spm_lut (
   input  wire logic                         clock,
   input  wire logic                         rd_en,
   input  wire logic [spm_pkg::DB_W-1:0]     rd_db_a,
   input  wire logic [spm_pkg::DB_W-1:0]     rd_db_b,
   output logic      [spm_pkg::LEVEL_W-1:0]  rd_lin_a,
   output logic      [spm_pkg::LEVEL_W-1:0]  rd_lin_b
);

   logic [spm_pkg::LEVEL_W-1:0] rom_mem [spm_pkg::LUT_DEPTH];
   logic [spm_pkg::LEVEL_W-1:0] rd_a_ff;
   logic [spm_pkg::LEVEL_W-1:0] rd_b_ff;
   logic [spm_pkg::DB_W-1:0]    addr_a;
   logic [spm_pkg::DB_W-1:0]    addr_b;

   for (genvar i = 0; i < spm_pkg::LUT_DEPTH; i++) begin : g_rom
      assign rom_mem[i] = spm_pkg::lin_entry(spm_pkg::DB_W'(i));
   end

   // flipping the sign bit turns the two's complement level into an offset index
   assign addr_a = rd_db_a ^ spm_pkg::DB_W'(spm_pkg::LUT_BIAS);
   assign addr_b = rd_db_b ^ spm_pkg::DB_W'(spm_pkg::LUT_BIAS);

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= rom_mem[addr_a];
         rd_b_ff <= rom_mem[addr_b];
      end
   end

   assign rd_lin_a = rd_a_ff;
   assign rd_lin_b = rd_b_ff;

endmodule

`default_nettype wire

[sv/spm_chan.sv]
// spm_chan: bar and peak-hold ballistics for one channel; holds the bar level,
// held peak and peak timestamp. Depends on spm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spm_chan (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire spm_pkg::spm_cfg_type        cfg,
   input  wire spm_pkg::spm_chan_req_type   req,
   output logic     [spm_pkg::LEVEL_W-1:0]  shown,
   output logic     [spm_pkg::LEVEL_W-1:0]  peak
);

   logic [spm_pkg::LEVEL_W-1:0]              shown_ff, shown_in;
   logic [spm_pkg::LEVEL_W-1:0]              peak_ff, peak_in;
   logic [spm_pkg::TIME_W-1:0]               peak_time_ff, peak_time_in;
   logic [spm_pkg::LEVEL_W+spm_pkg::COEF_W-1:0] bar_prod;
   logic [spm_pkg::LEVEL_W+spm_pkg::COEF_W-1:0] peak_prod;
   logic [spm_pkg::LEVEL_W-1:0]              fallen;
   logic [spm_pkg::LEVEL_W-1:0]              peak_fallen;
   logic [spm_pkg::TIME_W-1:0]               elapsed;
   logic                                     hold_over;

   assign bar_prod    = shown_ff * cfg.decay_coef;
   assign peak_prod   = peak_ff * cfg.peak_decay_coef;
   assign fallen      = bar_prod[spm_pkg::LEVEL_W+spm_pkg::COEF_W-1:spm_pkg::COEF_W];
   assign peak_fallen = peak_prod[spm_pkg::LEVEL_W+spm_pkg::COEF_W-1:spm_pkg::COEF_W];
   // modulo subtraction keeps the elapsed time right across counter wrap
   assign elapsed     = req.now - peak_time_ff;
   assign hold_over   = elapsed > {{(spm_pkg::TIME_W-spm_pkg::COEF_W){1'b0}}, cfg.hold_ms};

   always_comb begin
      shown_in     = shown_ff;
      peak_in      = peak_ff;
      peak_time_in = peak_time_ff;
      if (req.update) begin
         shown_in = (req.target > fallen) ? req.target : fallen;
         priority if (req.target > peak_ff) begin
            peak_in      = req.target;
            peak_time_in = req.now;
         end else if (hold_over) begin
            peak_in = peak_fallen;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shown_ff     <= '0;
         peak_ff      <= '0;
         peak_time_ff <= '0;
      end else begin
         shown_ff     <= shown_in;
         peak_ff      <= peak_in;
         peak_time_ff <= peak_time_in;
      end
   end

   assign shown = shown_ff;
   assign peak  = peak_ff;

endmodule

`default_nettype wire

[sv/stereo_peak_meter_ballistics_unit.sv]
// Stereo peak meter ballistics unit: top level with handshake, registers,
// table stage and two channel cores.
// Depends on spm_pkg, spm_lut, spm_chan.
//
// Usage:
//  - req channel: one request per accepted beat carries left and right levels
//    in eighth dB and a millisecond timestamp; rsp channel returns one beat per
//    request with both bar levels and both held peaks in linear Q2.14.
//  - csr channel: always ready; writes decay_coef, peak_decay_coef, hold_ms and
//    floor_db by index. Write only while no request is in flight.
//  - pipeline: an accepted request passes the table stage (registered ROM read)
//    and then the ballistics stage, whose registers are the response register.
//  - throughput: one request per cycle while responses are taken; the channel
//    state feeds back through a single multiply and compare each cycle.
//  - stall: when rsp_tready is low the response holds; the table stage still
//    takes one more request, then req_tready drops until the response is taken.
//  - reset: synchronous, clears bars, peaks, peak times and the pipeline and
//    loads the register defaults; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module stereo_peak_meter_ballistics_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // [10:0] left_db, [21:11] right_db, [53:22] timestamp_ms, [55:54] zero
   input  wire logic [spm_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // [15:0] display_left, [31:16] display_right, [47:32] peak_left, [63:48] peak_right
   output logic      [spm_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [spm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [spm_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int DW = spm_pkg::DB_W;
   localparam int TW = spm_pkg::TIME_W;
   localparam int LW = spm_pkg::LEVEL_W;

   spm_pkg::spm_cfg_type       cfg_ff, cfg_in;
   logic [DW-1:0]              floor_ff, floor_in;
   logic                       s1_valid_ff, s1_valid_in;
   logic                       s1_zero_l_ff, s1_zero_r_ff;
   logic [TW-1:0]              s1_now_ff;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       req_fire;
   logic                       s2_ready;
   logic [DW-1:0]              left_db;
   logic [DW-1:0]              right_db;
   logic [TW-1:0]              timestamp_ms;
   logic [LW-1:0]              lin_l, lin_r;
   logic [LW-1:0]              disp_l, disp_r, peak_l, peak_r;
   spm_pkg::spm_chan_req_type  chan_l_req, chan_r_req;

   assign left_db      = req_tdata[DW-1:0];
   assign right_db     = req_tdata[2*DW-1:DW];
   assign timestamp_ms = req_tdata[2*DW+TW-1:2*DW];

   assign s2_ready   = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || s2_ready;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // register file
   always_comb begin
      cfg_in   = cfg_ff;
      floor_in = floor_ff;
      if (csr_valid) begin
         unique case (csr_index)
            spm_pkg::CSR_DECAY_COEF:      cfg_in.decay_coef      = csr_data;
            spm_pkg::CSR_PEAK_DECAY_COEF: cfg_in.peak_decay_coef = csr_data;
            spm_pkg::CSR_HOLD_MS:         cfg_in.hold_ms         = csr_data;
            spm_pkg::CSR_FLOOR_DB:        floor_in               = csr_data[DW-1:0];
            default:                      cfg_in                 = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.decay_coef      <= spm_pkg::DECAY_COEF_RST;
         cfg_ff.peak_decay_coef <= spm_pkg::PEAK_DECAY_COEF_RST;
         cfg_ff.hold_ms         <= spm_pkg::HOLD_MS_RST;
         floor_ff               <= spm_pkg::FLOOR_DB_RST;
      end else begin
         cfg_ff   <= cfg_in;
         floor_ff <= floor_in;
      end
   end

   // table stage
   spm_lut u_lut (
      .clock    (clock),
      .rd_en    (req_fire),
      .rd_db_a  (left_db),
      .rd_db_b  (right_db),
      .rd_lin_a (lin_l),
      .rd_lin_b (lin_r)
   );

   assign s1_valid_in  = req_fire ? 1'b1 : (s1_valid_ff && !s2_ready);
   assign rsp_valid_in = s2_ready ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_zero_l_ff <= $signed(left_db) <= $signed(floor_ff);
         s1_zero_r_ff <= $signed(right_db) <= $signed(floor_ff);
         s1_now_ff    <= timestamp_ms;
      end
   end

   // ballistics stage
   always_comb begin
      chan_l_req.update = s1_valid_ff && s2_ready;
      chan_l_req.target = s1_zero_l_ff ? '0 : lin_l;
      chan_l_req.now    = s1_now_ff;
      chan_r_req.update = s1_valid_ff && s2_ready;
      chan_r_req.target = s1_zero_r_ff ? '0 : lin_r;
      chan_r_req.now    = s1_now_ff;
   end

   spm_chan u_chan_l (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg_ff),
      .req   (chan_l_req),
      .shown (disp_l),
      .peak  (peak_l)
   );

   spm_chan u_chan_r (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg_ff),
      .req   (chan_r_req),
      .shown (disp_r),
      .peak  (peak_r)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {peak_r, peak_l, disp_r, disp_l};

endmodule

`default_nettype wire

[sv/spm_checker.sv]
// spm_checker: port-level checks for the stereo peak meter ballistics unit,
// bound to the top level. Depends on spm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spm_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_tvalid,
   input wire logic                              req_tready,
   input wire logic                              rsp_tvalid,
   input wire logic                              rsp_tready,
   input wire logic [spm_pkg::RSP_DATA_W-1:0]    rsp_tdata
);

   // reset leaves no response pending
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // with an empty response register the block always takes a request
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request refused while response register empty");

   // the response to an accepted request follows when the receiver keeps up
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && rsp_tready) ##1 rsp_tready |-> ##1 rsp_tvalid)
      else $error("response missing two cycles after request");

   // a stalled response holds its data
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

endmodule

bind stereo_peak_meter_ballistics_unit spm_checker u_spm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

[verif/stereo_peak_meter_ballistics_unit_test.sv]
// Self-checking testbench for stereo_peak_meter_ballistics_unit: a directed table, then random
// stereo levels and timestamps over several register settings, each response checked against a
// behavioral model of the bars and held peaks or a typed reading. Depends on spm_pkg and the unit.
`timescale 1ns / 1ps

module stereo_peak_meter_ballistics_unit_test;

   localparam int NUM_PHASES        = 8;
   localparam int PHASE_REQUESTS    = 48;
   localparam int LONG_STALL_CYCLES = 300;
   localparam int CYCLE_LIMIT       = 200000;

   localparam int LEVEL_W = spm_pkg::LEVEL_W;
   localparam int TIME_W  = spm_pkg::TIME_W;
   localparam int COEF_W  = spm_pkg::COEF_W;

   // first member in the top bits, so display_left lands in rsp_tdata[15:0]
   typedef struct packed {
      logic [LEVEL_W-1:0] peak_right;
      logic [LEVEL_W-1:0] peak_left;
      logic [LEVEL_W-1:0] display_right;
      logic [LEVEL_W-1:0] display_left;
   } meter_reading_type;

   typedef struct packed {
      int                left_db;
      int                right_db;
      logic [TIME_W-1:0] stamp;
      bit                known;
      meter_reading_type reading;
   } meter_step_type;

   logic                              clock      = 1'b0;
   logic                              reset      = 1'b1;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic [spm_pkg::REQ_DATA_W-1:0]    req_tdata  = '0;
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   logic [spm_pkg::RSP_DATA_W-1:0]    rsp_tdata;
   logic                              csr_valid  = 1'b0;
   logic                              csr_ready;
   logic [spm_pkg::CSR_IDX_W-1:0]     csr_index  = '0;
   logic [spm_pkg::CSR_DATA_W-1:0]    csr_data   = '0;

   // model copy of the registers and per-channel state (0 = left, 1 = right)
   logic [COEF_W-1:0]  cfg_decay      = spm_pkg::DECAY_COEF_RST;
   logic [COEF_W-1:0]  cfg_peak_decay = spm_pkg::PEAK_DECAY_COEF_RST;
   logic [COEF_W-1:0]  cfg_hold       = spm_pkg::HOLD_MS_RST;
   int                 cfg_floor      = -480;
   logic [LEVEL_W-1:0] bar_level  [2] = '{16'd0, 16'd0};
   logic [LEVEL_W-1:0] peak_level [2] = '{16'd0, 16'd0};
   logic [TIME_W-1:0]  peak_stamp [2] = '{32'd0, 32'd0};

   meter_reading_type expected_readings [$];

   int requests_sent      = 0;
   int readings_checked   = 0;
   int mismatch_count     = 0;
   int cycle_count        = 0;
   int burst_left         = 0;
   bit paced              = 1'b1;
   bit long_stall_request = 1'b0;

   // directed rows under the reset settings (hold 2000 ms, floor -480)
   meter_step_type script [16] = '{
      '{-1024, -1024, 32'd0, 1'b1, '0},
      '{0, -480, 32'd10, 1'b1, '{peak_right: 16'd0, peak_left: 16'd16384,
                                 display_right: 16'd0, display_left: 16'd16384}},
      '{-1024, 0, 32'd5000, 1'b0, '0},
      '{-1024, 0, 32'd9000, 1'b0, '0},           // right target equals its peak
      '{-479, -481, 32'd9001, 1'b0, '0},         // just above and below the floor
      '{1023, 97, 32'd9002, 1'b1, '1},           // both saturate
      '{96, 48, 32'd9003, 1'b0, '0},
      '{-1024, -1024, 32'd11002, 1'b0, '0},      // elapsed equals hold: peaks held
      '{-1024, -1024, 32'd11003, 1'b0, '0},      // one past hold: peaks start to fall
      '{-1024, -1024, 32'hFFFF_FFFF, 1'b0, '0},
      '{47, -1, 32'd3, 1'b0, '0},
      '{-1024, -1024, 32'd2004, 1'b0, '0},
      '{-1024, -1024, 32'd1, 1'b0, '0},          // time runs backwards
      '{-1, -2, 32'h8000_0000, 1'b0, '0},
      '{-512, -1000, 32'h7FFF_FFFF, 1'b0, '0},
      '{-1023, 1, 32'h7FFF_FFFF, 1'b0, '0}
   };

   stereo_peak_meter_ballistics_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   function automatic logic [LEVEL_W-1:0] level_to_linear(int level);
      real lin;
      if (level <= cfg_floor) begin
         return '0;
      end
      lin = 16384.0 * $pow(10.0, real'(level) / 160.0);
      if (lin >= 65535.0) begin
         return '1;
      end
      return LEVEL_W'($rtoi(lin + 0.5));
   endfunction

   function automatic meter_reading_type advance_meter(int left_db, int right_db,
                                                       logic [TIME_W-1:0] now);
      int                 levels [2];
      int                 ch;
      logic [LEVEL_W-1:0] target;
      logic [LEVEL_W-1:0] fallen;
      meter_reading_type  reading;
      levels[0] = left_db;
      levels[1] = right_db;
      for (ch = 0; ch < 2; ch++) begin
         target = level_to_linear(levels[ch]);
         fallen = LEVEL_W'((32'(bar_level[ch]) * 32'(cfg_decay)) >> 16);
         bar_level[ch] = (target > fallen) ? target : fallen;
         if (target > peak_level[ch]) begin
            peak_level[ch] = target;
            peak_stamp[ch] = now;
         end else if (TIME_W'(now - peak_stamp[ch]) > 32'(cfg_hold)) begin
            peak_level[ch] = LEVEL_W'((32'(peak_level[ch]) * 32'(cfg_peak_decay)) >> 16);
         end
      end
      reading.display_left  = bar_level[0];
      reading.display_right = bar_level[1];
      reading.peak_left     = peak_level[0];
      reading.peak_right    = peak_level[1];
      return reading;
   endfunction

   // mostly levels around and above the floor, some repeats, some anywhere in 11 bits
   function automatic int pick_level(int previous);
      int pick;
      int lo;
      int level;
      pick = $urandom_range(0, 99);
      lo = (cfg_floor - 4 < -1024) ? -1024 : cfg_floor - 4;
      if (pick < 10) begin
         level = previous;
      end else if (pick < 50) begin
         level = (lo <= 48) ? lo + int'($urandom_range(0, 48 - lo))
                            : int'($urandom_range(0, 2047)) - 1024;
      end else if (pick < 70) begin
         level = cfg_floor + int'($urandom_range(0, 4)) - 2;
      end else if (pick < 90) begin
         level = int'($urandom_range(0, 1072)) - 1024;
      end else begin
         level = int'($urandom_range(0, 2047)) - 1024;
      end
      if (level < -1024) level = -1024;
      if (level > 1023) level = 1023;
      return level;
   endfunction

   task automatic send_levels(input int left_db, input int right_db,
                              input logic [TIME_W-1:0] now,
                              input bit known, input meter_reading_type typed);
      meter_reading_type predicted;
      int                gap;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, now, 11'(right_db), 11'(left_db)};
      do @(posedge clock); while (!req_tready);
      predicted = advance_meter(left_db, right_db, now);
      expected_readings.push_back(known ? typed : predicted);
      requests_sent++;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = paced ? $urandom_range(0, 6) : 0;
         if (gap > 0) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   task automatic write_register(input logic [spm_pkg::CSR_IDX_W-1:0] index,
                                 input logic [spm_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (index)
         spm_pkg::CSR_DECAY_COEF:      cfg_decay      = value;
         spm_pkg::CSR_PEAK_DECAY_COEF: cfg_peak_decay = value;
         spm_pkg::CSR_HOLD_MS:         cfg_hold       = value;
         spm_pkg::CSR_FLOOR_DB:        cfg_floor = int'($signed(value[spm_pkg::DB_W-1:0]));
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // stop offering and let every outstanding response come back
   task automatic drain_pending();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_readings.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin : receiver
      int mode;
      int tick;
      mode = 0;
      tick = 0;
      forever begin
         @(negedge clock);
         if (long_stall_request) begin
            long_stall_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LONG_STALL_CYCLES - 1) @(negedge clock);
         end else begin
            if (tick % 64 == 0) mode = $urandom_range(0, 3);
            case (mode)
               0:       rsp_tready <= 1'b1;
               1:       rsp_tready <= 1'($urandom_range(0, 1));
               2:       rsp_tready <= (tick % 4) != 3;
               default: rsp_tready <= $urandom_range(0, 9) != 0;
            endcase
            tick++;
         end
      end
   end

   always @(posedge clock) begin : check_readings
      meter_reading_type got;
      meter_reading_type wanted;
      string             field_name [4];
      int                f;
      field_name = '{"display_left", "display_right", "peak_left", "peak_right"};
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = meter_reading_type'(rsp_tdata);
         if (expected_readings.size() == 0) begin
            $display("%0t: response with no request pending: %h", $time, rsp_tdata);
            mismatch_count++;
         end else begin
            wanted = expected_readings.pop_front();
            for (f = 0; f < 4; f++) begin
               if (got[f*LEVEL_W +: LEVEL_W] !== wanted[f*LEVEL_W +: LEVEL_W]) begin
                  $display("%0t: %s expected %0d, got %0d", $time, field_name[f],
                           wanted[f*LEVEL_W +: LEVEL_W], got[f*LEVEL_W +: LEVEL_W]);
                  mismatch_count++;
               end
            end
            readings_checked++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding", cycle_count,
                  expected_readings.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      int                p;
      int                i;
      int                pick;
      int                left_db;
      int                right_db;
      int                floor_db;
      logic [TIME_W-1:0] now;
      logic [COEF_W-1:0] decay;
      logic [COEF_W-1:0] peak_decay;
      logic [COEF_W-1:0] hold;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (i = 0; i < $size(script); i++) begin
         send_levels(script[i].left_db, script[i].right_db, script[i].stamp,
                     script[i].known, script[i].reading);
      end

      left_db  = -1024;
      right_db = -1024;
      for (p = 0; p < NUM_PHASES; p++) begin
         drain_pending();
         decay      = COEF_W'($urandom());
         peak_decay = COEF_W'($urandom());
         hold       = COEF_W'($urandom_range(0, 3000));
         floor_db   = int'($urandom_range(0, 1024)) - 1024;
         case (p)
            0: begin
               decay = '0; peak_decay = '0; hold = '0; floor_db = -1024;
            end
            1: begin
               decay = '1; peak_decay = '1; hold = '1; floor_db = 0;
            end
            2: begin
               decay = spm_pkg::DECAY_COEF_RST; peak_decay = spm_pkg::PEAK_DECAY_COEF_RST;
               hold = spm_pkg::HOLD_MS_RST; floor_db = -480;
            end
            3: floor_db = 1023;   // floor above every level: all targets zero
            4: begin
               decay = 16'h8000; peak_decay = '1; hold = 16'd1; floor_db = -1;
            end
            default: ;
         endcase
         write_register(spm_pkg::CSR_DECAY_COEF, decay);
         write_register(spm_pkg::CSR_PEAK_DECAY_COEF, peak_decay);
         write_register(spm_pkg::CSR_HOLD_MS, hold);
         write_register(spm_pkg::CSR_FLOOR_DB, spm_pkg::CSR_DATA_W'(floor_db));

         // two phases run back to back against a long receiver hold-off
         paced = !(p == 2 || p == 6);
         if (!paced) long_stall_request = 1'b1;
         now = $urandom();
         for (i = 0; i < PHASE_REQUESTS; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
               now += $urandom_range(0, 32'(hold) + 32'(hold) / 2 + 4);
            end else if (pick < 55) begin
               now += 32'(hold);
            end else if (pick < 70) begin
               now += 32'(hold) + 1;
            end else if (pick < 80) begin
               now += 0;
            end else if (pick < 92) begin
               now += $urandom_range(0, 20);
            end else begin
               now = $urandom();
            end
            left_db  = pick_level(left_db);
            right_db = pick_level(right_db);
            send_levels(left_db, right_db, now, 1'b0, '0);
         end
      end

      drain_pending();
      $display("%0d requests over %0d register settings;", requests_sent, NUM_PHASES + 1);
      $display("%0d responses compared, %0d mismatches", readings_checked, mismatch_count);
      if (mismatch_count == 0 && expected_readings.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
